// File: rtl/pbd_pkg.sv
// ----------------------------------------------------------------------------
// pbd_pkg: shared constants and tables for the point bearing/distance unit
// Holds the whole-degree sine table in unsigned Q0.48 and the quadrant codes.
// ----------------------------------------------------------------------------
package pbd_pkg;

  // sine table format: 48 fraction bits, multiplied as two 24-bit halves
  localparam int SIN_W  = 48;
  localparam int HALF_W = 24;

  // bearing search: seven binary steps, each a multiply stage and a compare stage
  localparam int BEAR_STEPS = 7;
  localparam int BEAR_ITERS = 2 * BEAR_STEPS;
  localparam int DEG_W      = 7;
  localparam int MAX_FRAC   = 89;
  localparam int BEAR_W     = 9;

  // quadrant codes
  localparam logic [1:0] QUAD_E = 2'd0;
  localparam logic [1:0] QUAD_N = 2'd1;
  localparam logic [1:0] QUAD_W = 2'd2;
  localparam logic [1:0] QUAD_S = 2'd3;

  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C234;

  typedef logic [SIN_W-1:0] sin_tab_t [0:90];
  typedef logic [BEAR_W-1:0] quad_base_t [0:3];

  localparam quad_base_t QUAD_BASE = '{9'd0, 9'd90, 9'd180, 9'd270};

  // floor(a * b / 2^62)
  function automatic logic [63:0] mul_q(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Taylor series of sin at every whole degree, in Q2.62, cut to Q0.48
  function automatic sin_tab_t build_sin_tab();
    logic [63:0] step;
    logic [63:0] rem;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    sin_tab_t    t;
    step = PI_Q62 / 64'd180;
    rem  = PI_Q62 % 64'd180;
    for (int d = 0; d <= 90; d++) begin
      x    = step * 64'(d) + (rem * 64'(d)) / 64'd180;
      x2   = mul_q(x, x);
      sum  = x;
      term = x;
      for (int n = 1; n <= 40; n++) begin
        if (term != 64'd0) begin
          term = mul_q(term, x2) / 64'((2 * n) * (2 * n + 1));
          if ((n % 2) == 1) begin
            sum = sum - term;
          end else begin
            sum = sum + term;
          end
        end
      end
      t[d] = sum[61:14];
    end
    return t;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

// File: rtl/point_bearing_and_distance_unit.sv
// ----------------------------------------------------------------------------
// point_bearing_and_distance_unit: distance and whole-degree bearing of two points
// Fully pipelined: integer square root one bit per stage, bearing found by a
// binary search over whole degrees with exact table compares.
// ----------------------------------------------------------------------------
// Takes one point pair every clock; busy is always low. Each pair's result
// appears on the out_ ports for one cycle, marked by out_valid, once it has
// passed the difference, fold/square, sum, search/root and output registers.
// The square root (one result bit per stage) and the bearing search (seven
// multiply/compare step pairs) run side by side; the longer sets the depth.
// Results cannot be held off; the receiver must take every beat. The radius
// register is written through cfg_valid/cfg_ready, always ready, and should
// change only while no pair is in flight.
module point_bearing_and_distance_unit #(
  parameter int COORD_BITS = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [7:0]            cfg_radius,
  output logic                  out_valid,
  output logic [COORD_BITS:0]   out_distance,
  output logic [8:0]            out_bearing_deg,
  output logic                  out_inside_radius
);

  localparam int DIST_W = COORD_BITS + 1;
  localparam int SQ_W   = 2 * COORD_BITS + 1;
  localparam int INC_W  = 2 * DIST_W + 1;
  localparam int ITERS  = (DIST_W > pbd_pkg::BEAR_ITERS) ? DIST_W : pbd_pkg::BEAR_ITERS;
  localparam int PROD_W = COORD_BITS + pbd_pkg::HALF_W;
  localparam int CMP_W  = COORD_BITS + pbd_pkg::SIN_W;

  typedef struct packed {
    logic [COORD_BITS-1:0]   a;
    logic [COORD_BITS-1:0]   b;
    logic [1:0]              quad;
    logic                    nz;
    logic [pbd_pkg::DEG_W-1:0] lo;
    logic [PROD_W-1:0]       lb_hi;
    logic [PROD_W-1:0]       lb_lo;
    logic [PROD_W-1:0]       ra_hi;
    logic [PROD_W-1:0]       ra_lo;
    logic [SQ_W-1:0]         rem;
    logic [DIST_W-1:0]       root;
  } stage_t;

  logic                         accept;
  logic [7:0]                   radius_r;
  logic                         vld1_r;
  logic                         vld2_r;
  logic signed [COORD_BITS:0]   u_r;
  logic signed [COORD_BITS:0]   v_r;
  logic [COORD_BITS-1:0]        a2_r;
  logic [COORD_BITS-1:0]        b2_r;
  logic [1:0]                   quad2_r;
  logic                         nz2_r;
  logic [2*COORD_BITS-1:0]      squ2_r;
  logic [2*COORD_BITS-1:0]      sqv2_r;
  logic [COORD_BITS-1:0]        a_nxt;
  logic [COORD_BITS-1:0]        b_nxt;
  logic [1:0]                   quad_nxt;
  logic [COORD_BITS-1:0]        abs_u;
  logic [COORD_BITS-1:0]        abs_v;
  logic                         vld_r  [0:ITERS];
  stage_t                       pipe_r [0:ITERS];
  stage_t                       pipe_nxt [1:ITERS];
  logic                         out_valid_r;
  logic [DIST_W-1:0]            out_distance_r;
  logic [8:0]                   out_bearing_r;
  logic                         out_inside_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // hold the radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 8'd2;
    end else if (cfg_valid && cfg_ready) begin
      radius_r <= cfg_radius;
    end
  end

  // stage 1: difference vector, y flipped to grow upward
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= accept;
    end
    u_r <= $signed({1'b0, in_second_x}) - $signed({1'b0, in_first_x});
    v_r <= $signed({1'b0, in_first_y}) - $signed({1'b0, in_second_y});
  end

  // fold the vector into the first quadrant
  assign abs_u = u_r[COORD_BITS] ? COORD_BITS'(-u_r) : COORD_BITS'(u_r);
  assign abs_v = v_r[COORD_BITS] ? COORD_BITS'(-v_r) : COORD_BITS'(v_r);

  always_comb begin
    if (u_r > 0 && v_r >= 0) begin
      quad_nxt = pbd_pkg::QUAD_E;
      a_nxt    = COORD_BITS'(u_r);
      b_nxt    = COORD_BITS'(v_r);
    end else if (u_r <= 0 && v_r > 0) begin
      quad_nxt = pbd_pkg::QUAD_N;
      a_nxt    = COORD_BITS'(v_r);
      b_nxt    = COORD_BITS'(-u_r);
    end else if (u_r < 0 && v_r <= 0) begin
      quad_nxt = pbd_pkg::QUAD_W;
      a_nxt    = COORD_BITS'(-u_r);
      b_nxt    = COORD_BITS'(-v_r);
    end else begin
      quad_nxt = pbd_pkg::QUAD_S;
      a_nxt    = COORD_BITS'(-v_r);
      b_nxt    = COORD_BITS'(u_r);
    end
  end

  // stage 2: quadrant fold and squares
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    a2_r    <= a_nxt;
    b2_r    <= b_nxt;
    quad2_r <= quad_nxt;
    nz2_r   <= (u_r != 0) || (v_r != 0);
    squ2_r  <= (2*COORD_BITS)'(abs_u) * (2*COORD_BITS)'(abs_u);
    sqv2_r  <= (2*COORD_BITS)'(abs_v) * (2*COORD_BITS)'(abs_v);
  end

  // stage 3: sum of squares, open the search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= vld2_r;
    end
    pipe_r[0].a     <= a2_r;
    pipe_r[0].b     <= b2_r;
    pipe_r[0].quad  <= quad2_r;
    pipe_r[0].nz    <= nz2_r;
    pipe_r[0].lo    <= '0;
    pipe_r[0].lb_hi <= '0;
    pipe_r[0].lb_lo <= '0;
    pipe_r[0].ra_hi <= '0;
    pipe_r[0].ra_lo <= '0;
    pipe_r[0].rem   <= SQ_W'(squ2_r) + SQ_W'(sqv2_r);
    pipe_r[0].root  <= '0;
  end

  // search and square root stages
  for (genvar k = 0; k < ITERS; k++) begin : g_iter
    localparam int BITPOS = ITERS - 1 - k;

    stage_t                    cur;
    stage_t                    mid;

    assign cur     = pipe_r[k];

    if (k < pbd_pkg::BEAR_ITERS) begin : g_bear
      localparam logic [pbd_pkg::DEG_W-1:0] STEP =
        pbd_pkg::DEG_W'(64 >> ((k / 2) % pbd_pkg::BEAR_STEPS));

      logic [pbd_pkg::DEG_W-1:0] cand;
      logic                      cand_ok;
      logic [pbd_pkg::DEG_W-1:0] idx;

      assign cand    = cur.lo + STEP;
      assign cand_ok = (cand != '0) && (cand <= pbd_pkg::DEG_W'(pbd_pkg::MAX_FRAC))
                       && (cand >= cur.lo);
      assign idx     = cand_ok ? cand : pbd_pkg::DEG_W'(1);

      if ((k % 2) == 0) begin : g_mul
        logic [pbd_pkg::SIN_W-1:0] cos_c;
        logic [pbd_pkg::SIN_W-1:0] sin_c;
        // multiply both sides against the candidate degree
        always_comb begin
          cos_c     = pbd_pkg::SIN_TAB[7'd90 - idx];
          sin_c     = pbd_pkg::SIN_TAB[idx];
          mid       = cur;
          mid.lb_hi = PROD_W'(cur.b) * PROD_W'(cos_c[pbd_pkg::SIN_W-1:pbd_pkg::HALF_W]);
          mid.lb_lo = PROD_W'(cur.b) * PROD_W'(cos_c[pbd_pkg::HALF_W-1:0]);
          mid.ra_hi = PROD_W'(cur.a) * PROD_W'(sin_c[pbd_pkg::SIN_W-1:pbd_pkg::HALF_W]);
          mid.ra_lo = PROD_W'(cur.a) * PROD_W'(sin_c[pbd_pkg::HALF_W-1:0]);
        end
      end else begin : g_cmp
        logic [CMP_W-1:0] lhs;
        logic [CMP_W-1:0] rhs;
        // advance the lower bound when the vector lies at or above the candidate
        always_comb begin
          lhs = {cur.lb_hi, {pbd_pkg::HALF_W{1'b0}}} + CMP_W'(cur.lb_lo);
          rhs = {cur.ra_hi, {pbd_pkg::HALF_W{1'b0}}} + CMP_W'(cur.ra_lo);
          mid = cur;
          if (cand_ok && lhs >= rhs) begin
            mid.lo = cand;
          end
        end
      end
    end else begin : g_bpass
      assign mid = cur;
    end

    if (BITPOS < DIST_W) begin : g_sqrt
      logic [INC_W-1:0] inc;
      // try the next root bit
      always_comb begin
        inc         = (INC_W'(mid.root) << (BITPOS + 1)) + (INC_W'(1) << (2 * BITPOS));
        pipe_nxt[k+1] = mid;
        if (INC_W'(mid.rem) >= inc) begin
          pipe_nxt[k+1].rem          = mid.rem - SQ_W'(inc);
          pipe_nxt[k+1].root[BITPOS] = 1'b1;
        end
      end
    end else begin : g_spass
      assign pipe_nxt[k+1] = mid;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else begin
        vld_r[k+1] <= vld_r[k];
      end
      pipe_r[k+1] <= pipe_nxt[k+1];
    end
  end

  // output beat: bearing assembly and radius test
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[ITERS];
    end
    out_distance_r <= pipe_r[ITERS].root;
    out_bearing_r  <= pipe_r[ITERS].nz
                      ? pbd_pkg::QUAD_BASE[pipe_r[ITERS].quad] + 9'(pipe_r[ITERS].lo)
                      : 9'd0;
    out_inside_r   <= pipe_r[ITERS].root < DIST_W'(radius_r);
  end

  assign out_valid         = out_valid_r;
  assign out_distance      = out_distance_r;
  assign out_bearing_deg   = out_bearing_r;
  assign out_inside_radius = out_inside_r;

endmodule

// File: rtl/pbd_checker.sv
// ----------------------------------------------------------------------------
// pbd_checker: port-level checks for the point bearing/distance unit
// Watches result beats and the radius flag; attached to the top by bind.
// ----------------------------------------------------------------------------
module pbd_checker #(
  parameter int COORD_BITS = 15
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input logic [COORD_BITS:0] out_distance,
  input logic [8:0]          out_bearing_deg,
  input logic                out_inside_radius
);

  // a bearing is always a whole degree below a full turn
  a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bearing_deg <= 9'd359)
    else $error("bearing out of range");

  // the radius is eight bits, so an inside point is closer than 255
  a_inside_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inside_radius |-> out_distance < (COORD_BITS+1)'(255))
    else $error("inside flag with distance beyond any radius");

  // identical points face east
  a_zero_bearing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_distance == '0 |-> out_bearing_deg == 9'd0)
    else $error("zero distance with nonzero bearing");

  // the unit never refuses a pair
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy)
    else $error("busy raised");

endmodule

bind point_bearing_and_distance_unit pbd_checker #(.COORD_BITS(COORD_BITS)) u_pbd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_distance      (out_distance),
  .out_bearing_deg   (out_bearing_deg),
  .out_inside_radius (out_inside_radius)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for point_bearing_and_distance_unit
// Feeds point pairs through the start/busy port and predicts the floor of the
// distance, the whole-degree bearing and the inside flag for each pair. Every
// out_valid beat is checked against the oldest prediction. The radius register
// is rewritten between phases while the unit is drained.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CB         = 15;
  localparam int PIPE_DEPTH = 20;
  localparam int CYCLE_CAP  = 400000;
  localparam logic [63:0] PI_FIX = 64'hC90FDAA22168C234;

  typedef struct {
    logic [CB:0]  distance;
    logic [8:0]   bearing;
    logic         near_flag;
  } fix_t;

  // Prediction of distance, bearing and inside flag for each accepted pair
  class bearing_scoreboard;
    logic [63:0] sine_q62 [0:90];
    logic [7:0]  radius;
    fix_t        expected_fixes [$];
    int          errors;
    int          checked;

    function new();
      logic [63:0] step_q;
      logic [63:0] rem_q;
      logic [63:0] ang;
      logic [63:0] ang2;
      logic [63:0] acc;
      logic [63:0] term;
      radius  = 8'd2;
      errors  = 0;
      checked = 0;
      step_q  = PI_FIX / 64'd180;
      rem_q   = PI_FIX % 64'd180;
      // Taylor series per degree, every product truncated to Q2.62
      for (int d = 0; d <= 90; d++) begin
        ang  = step_q * 64'(d) + (rem_q * 64'(d)) / 64'd180;
        ang2 = q62_product(ang, ang);
        acc  = ang;
        term = ang;
        for (int n = 1; n <= 40 && term != 64'd0; n++) begin
          term = q62_product(term, ang2) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
        sine_q62[d] = acc;
      end
    endfunction

    function logic [63:0] q62_product(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
    endfunction

    // true when (a, b) lies at or above the ray of d degrees
    function bit on_or_over_ray(logic [63:0] a, logic [63:0] b, int d);
      logic [127:0] lhs;
      logic [127:0] rhs;
      if (d == 45) return b >= a;
      lhs = {64'd0, b} * {64'd0, sine_q62[90 - d]};
      rhs = {64'd0, a} * {64'd0, sine_q62[d]};
      return lhs >= rhs;
    endfunction

    function logic [31:0] floor_sqrt(logic [31:0] n);
      logic [31:0] root;
      root = 0;
      for (int k = 15; k >= 0; k--) begin
        if ((root | (32'd1 << k)) * (root | (32'd1 << k)) <= n) root = root | (32'd1 << k);
      end
      return root;
    endfunction

    function void note_pair(int x1, int y1, int x2, int y2);
      int          u;
      int          v;
      int          a;
      int          b;
      int          frac;
      logic [1:0]  quad;
      logic [31:0] sq;
      fix_t        f;
      u  = x2 - x1;
      v  = y1 - y2;
      sq = 32'(u * u) + 32'(v * v);
      f.distance = (CB+1)'(floor_sqrt(sq));
      f.bearing  = 9'd0;
      if (u != 0 || v != 0) begin
        if (u > 0 && v >= 0) begin
          quad = pbd_pkg::QUAD_E; a = u; b = v;
        end else if (u <= 0 && v > 0) begin
          quad = pbd_pkg::QUAD_N; a = v; b = -u;
        end else if (u < 0 && v <= 0) begin
          quad = pbd_pkg::QUAD_W; a = -u; b = -v;
        end else begin
          quad = pbd_pkg::QUAD_S; a = -v; b = u;
        end
        frac = 0;
        for (int d = 1; d <= 89; d++) begin
          if (!on_or_over_ray(64'(a), 64'(b), d)) break;
          frac = d;
        end
        f.bearing = 9'(int'(quad) * 90 + frac);
      end
      f.near_flag = (32'(f.distance) < 32'(radius));
      expected_fixes.insert(expected_fixes.size(), f);
    endfunction

    function void check_result(logic [CB:0] got_dist, logic [8:0] got_bearing,
                               logic got_near);
      fix_t f;
      if (expected_fixes.size() == 0) begin
        $display("%0t: unexpected result beat dist=%0d bearing=%0d inside=%0b",
                 $time, got_dist, got_bearing, got_near);
        errors++;
        return;
      end
      f = expected_fixes[0];
      expected_fixes.delete(0);
      checked++;
      if (got_dist !== f.distance) begin
        $display("%0t: distance expected %0d actual %0d", $time, f.distance, got_dist);
        errors++;
      end
      if (got_bearing !== f.bearing) begin
        $display("%0t: bearing expected %0d actual %0d", $time, f.bearing, got_bearing);
        errors++;
      end
      if (got_near !== f.near_flag) begin
        $display("%0t: inside flag expected %0b actual %0b", $time, f.near_flag, got_near);
        errors++;
      end
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [CB-1:0] in_first_x;
  logic [CB-1:0] in_first_y;
  logic [CB-1:0] in_second_x;
  logic [CB-1:0] in_second_y;
  logic          cfg_valid;
  logic          cfg_ready;
  logic [7:0]    cfg_radius;
  logic          out_valid;
  logic [CB:0]   out_distance;
  logic [8:0]    out_bearing_deg;
  logic          out_inside_radius;

  bearing_scoreboard sb;
  int cycles;
  int pairs_sent;
  int radii_used;

  point_bearing_and_distance_unit #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_first_x(in_first_x), .in_first_y(in_first_y),
    .in_second_x(in_second_x), .in_second_y(in_second_y),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_radius(cfg_radius),
    .out_valid(out_valid), .out_distance(out_distance),
    .out_bearing_deg(out_bearing_deg), .out_inside_radius(out_inside_radius)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every result beat and bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) sb.check_result(out_distance, out_bearing_deg, out_inside_radius);
    if (cycles > CYCLE_CAP) begin
      $display("FAIL point_bearing_and_distance_unit");
      $finish;
    end
  end

  // Present one pair and hold it until accepted; gap counts idle cycles first
  task automatic send_pair(int x1, int y1, int x2, int y2, int gap);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_first_x  = CB'(x1);
    in_first_y  = CB'(y1);
    in_second_x = CB'(x2);
    in_second_y = CB'(y2);
    start       = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_pair(x1, y1, x2, y2);
    pairs_sent++;
  endtask

  // Wait for every expected beat plus the pipeline depth
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.expected_fixes.size() != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);
  endtask

  // Write the radius while the unit is drained
  task automatic write_radius(logic [7:0] r);
    drain();
    cfg_radius = r;
    cfg_valid  = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.radius = r;
    radii_used++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Random pair: mostly short hops around a random origin, some full range
  task automatic random_pair(int gap);
    int x1;
    int y1;
    int span;
    x1 = $urandom_range(32767);
    y1 = $urandom_range(32767);
    case ($urandom_range(3))
      0: span = 3;
      1: span = 40;
      2: span = 400;
      default: span = 32767;
    endcase
    if (span == 32767) begin
      send_pair(x1, y1, $urandom_range(32767), $urandom_range(32767), gap);
    end else begin
      send_pair(x1, y1,
                (x1 + $urandom_range(2 * span) - span) & 32'h7FFF,
                (y1 + $urandom_range(2 * span) - span) & 32'h7FFF, gap);
    end
  endtask

  initial begin
    logic [7:0] radii [4];
    int         burst;
    sb          = new();
    cycles      = 0;
    pairs_sent  = 0;
    radii_used  = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    cfg_valid   = 1'b0;
    cfg_radius  = 8'd0;
    in_first_x  = '0;
    in_first_y  = '0;
    in_second_x = '0;
    in_second_y = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: identical points, axes, diagonals, extremes, near-radius hops
    send_pair(0, 0, 0, 0, 0);
    send_pair(32767, 32767, 32767, 32767, 0);
    send_pair(100, 100, 101, 100, 0);
    send_pair(100, 100, 100, 99, 0);
    send_pair(100, 100, 99, 100, 0);
    send_pair(100, 100, 100, 101, 0);
    send_pair(100, 100, 101, 99, 0);
    send_pair(100, 100, 99, 99, 0);
    send_pair(100, 100, 99, 101, 0);
    send_pair(100, 100, 101, 101, 0);
    send_pair(0, 0, 32767, 32767, 0);
    send_pair(32767, 32767, 0, 0, 0);
    send_pair(0, 32767, 32767, 0, 0);
    send_pair(32767, 0, 0, 32767, 0);
    send_pair(0, 0, 32767, 0, 0);
    send_pair(0, 0, 0, 32767, 0);
    send_pair(0, 0, 32767, 1, 0);
    send_pair(0, 1, 32767, 0, 0);
    send_pair(5, 5, 6, 6, 0);
    send_pair(5, 5, 7, 5, 0);
    send_pair(21845, 10922, 10922, 21845, 0);

    // Random phases at several radius settings, extremes included
    radii[0] = 8'd0;
    radii[1] = 8'd255;
    radii[2] = 8'($urandom_range(1, 254));
    radii[3] = 8'd1;
    foreach (radii[p]) begin
      write_radius(radii[p]);
      for (int i = 0; i < 270; i++) begin
        if (i == 135) drain();
        burst = (p % 2 == 0 && i < 60) ? 0 : $urandom_range(18);
        random_pair($urandom_range(3) == 0 ? 0 : burst);
      end
    end

    drain();
    repeat (PIPE_DEPTH) @(negedge clk);
    if (sb.expected_fixes.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_fixes.size());
      sb.errors++;
    end
    $display("Run: %0d point pairs sent, %0d results checked, %0d radius writes.",
             pairs_sent, sb.checked, radii_used);
    if (sb.errors == 0) begin
      $display("PASS point_bearing_and_distance_unit");
    end else begin
      $display("FAIL point_bearing_and_distance_unit");
    end
    $finish;
  end
endmodule
